// ===== src/rcn_pkg.sv =====
`default_nettype none

package rcn_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int POS_W    = 14;
  localparam int DIR_W    = 16;
  localparam int OUT_W    = 16;
  localparam int CD_W     = 6;
  localparam int REACH_W  = 10;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 10;
  localparam int MW       = 62;
  localparam int SQ_STEPS = MW / 2;
  localparam int HIT_SH   = 28;
  localparam int MISS_SH  = 10;

  localparam logic [CD_W-1:0]    CD_RESET    = 6'd30;
  localparam logic [REACH_W-1:0] REACH_RESET = 10'd500;

  localparam logic [CFG_IW-1:0] CFG_CONTACT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_REACH   = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_WR, OP_QRY, OP_ORG, OP_DIFF,
    OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
    OP_BB, OP_SQST, OP_UPD, OP_FMX, OP_FSX, OP_FSY
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [SLOT_AW-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic inact;
    logic eval_ok;
    logic h_ok;
    logic sq_done;
  } dp_stat_t;

  // round half up of (o << sh + p) / 2^sh, saturated to 16 bits
  function automatic logic [OUT_W-1:0] rnd_sat(input logic [POS_W-1:0] o,
                                               input logic signed [MW-1:0] p,
                                               input logic hit);
    logic signed [47:0] s;
    logic signed [47:0] r;
    if (hit) begin
      s = ($signed({34'd0, o}) <<< HIT_SH) + $signed(p[47:0]) + (48'sd1 <<< (HIT_SH - 1));
      r = s >>> HIT_SH;
    end else begin
      s = ($signed({34'd0, o}) <<< MISS_SH) + $signed(p[47:0]) + (48'sd1 <<< (MISS_SH - 1));
      r = s >>> MISS_SH;
    end
    if (r > 48'sd32767) begin
      return 16'h7FFF;
    end else if (r < -48'sd32768) begin
      return 16'h8000;
    end else begin
      return r[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/ray_circle_nearest_hit_core.sv =====
// channel  | handshake        | fields
// ---------+------------------+-----------------------------------------------
// command  | start_i / busy_o | cmd_i slot_index_i centre_x/y_i inactive_i dir_x/y_i
// result   | done_o (strobe)  | hit_o contact_x/y_o target_x/y_o
// config   | cfg_we_i         | cfg_idx_i cfg_data_i
//
// A slot write does not raise busy_o. A query scans slots 1..15 against the origin in slot 0;
// an inactive slot is skipped, and only a candidate runs the 31-step square root.
// The steps share one 32x32 multiplier, and the root unit finds one bit a cycle.
// Reset marks every slot inactive and loads the register defaults.
// Results cannot be stalled; done_o is high for one cycle per query.
`default_nettype none

module ray_circle_nearest_hit_core import rcn_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    cmd_i,
  input  wire logic [SLOT_AW-1:0]      slot_index_i,
  input  wire logic [POS_W-1:0]        centre_x_i,
  input  wire logic [POS_W-1:0]        centre_y_i,
  input  wire logic                    inactive_i,
  input  wire logic signed [DIR_W-1:0] dir_x_i,
  input  wire logic signed [DIR_W-1:0] dir_y_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IW-1:0]       cfg_idx_i,
  input  wire logic [CFG_DW-1:0]       cfg_data_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [OUT_W-1:0]      contact_x_o,
  output logic signed [OUT_W-1:0]      contact_y_o,
  output logic [POS_W-1:0]             target_x_o,
  output logic [POS_W-1:0]             target_y_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rcn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  rcn_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .slot_index_i (slot_index_i),
    .centre_x_i   (centre_x_i),
    .centre_y_i   (centre_y_i),
    .inactive_i   (inactive_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .hit_o        (hit_o),
    .contact_x_o  (contact_x_o),
    .contact_y_o  (contact_y_o),
    .target_x_o   (target_x_o),
    .target_y_o   (target_y_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe outside a query");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("query did not end after its result");

  a_miss_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (target_x_o == '0 && target_y_o == '0))
    else $error("miss with non-zero target");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_QUERY) |=> (busy_o && !done_o))
    else $error("query not taken up");

endmodule

`default_nettype wire

// ===== src/rcn_sqrt.sv =====
`default_nettype none

module rcn_sqrt import rcn_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MW-1:0]       v_i,
  output logic                     done_o,
  output logic [SQ_STEPS-1:0]      root_o
);

  localparam int CW = $clog2(SQ_STEPS);

  logic [MW-1:0] v_q, r_q, bit_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic [MW-1:0] sum;

  assign sum = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(SQ_STEPS - 1);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      r_q   <= '0;
      bit_q <= MW'(1) << (MW - 2);
    end else if (run_q) begin
      if (v_q >= sum) begin
        v_q <= v_q - sum;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = !run_q;
  assign root_o = r_q[SQ_STEPS-1:0];

endmodule

`default_nettype wire

// ===== src/rcn_ctrl.sv =====
`default_nettype none

module rcn_ctrl import rcn_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     cmd_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_ORG   = 17'h00002,
    S_FETCH = 17'h00004,
    S_DIFF  = 17'h00008,
    S_M1    = 17'h00010,
    S_M2    = 17'h00020,
    S_M3    = 17'h00040,
    S_M4    = 17'h00080,
    S_M5    = 17'h00100,
    S_EVAL  = 17'h00200,
    S_HCHK  = 17'h00400,
    S_SQ    = 17'h00800,
    S_UPD   = 17'h01000,
    S_FX    = 17'h02000,
    S_FXA   = 17'h04000,
    S_FYA   = 17'h08000,
    S_OUT   = 17'h10000
  } state_e;

  state_e             state_q, state_d;
  logic [SLOT_AW-1:0] idx_q, idx_d;
  logic               last;

  assign last = (idx_q == SLOT_AW'(SLOTS - 1));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o.op   = OP_NONE;
    cmd_o.addr = idx_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.addr = '0;
        if (start_i) begin
          if (cmd_i == CMD_QUERY) begin
            cmd_o.op = OP_QRY;
            state_d  = S_ORG;
          end else begin
            cmd_o.op = OP_WR;
          end
        end
      end
      S_ORG: begin
        cmd_o.op = OP_ORG;
        idx_d    = SLOT_AW'(1);
        state_d  = S_FETCH;
      end
      S_FETCH: begin
        if (stat_i.inact) begin
          if (last) begin
            state_d = S_FX;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_M1;
      end
      S_M1: begin
        cmd_o.op = OP_M1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = OP_M2;
        state_d  = S_M3;
      end
      S_M3: begin
        cmd_o.op = OP_M3;
        state_d  = S_M4;
      end
      S_M4: begin
        cmd_o.op = OP_M4;
        state_d  = S_M5;
      end
      S_M5: begin
        cmd_o.op = OP_M5;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.op = OP_BB;
        if (stat_i.eval_ok) begin
          state_d = S_HCHK;
        end else if (last) begin
          state_d = S_FX;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FETCH;
        end
      end
      S_HCHK: begin
        cmd_o.op = OP_SQST;
        if (stat_i.h_ok) begin
          state_d = S_SQ;
        end else if (last) begin
          state_d = S_FX;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FETCH;
        end
      end
      S_SQ: begin
        if (stat_i.sq_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        if (last) begin
          state_d = S_FX;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FX: begin
        cmd_o.op = OP_FMX;
        state_d  = S_FXA;
      end
      S_FXA: begin
        cmd_o.op = OP_FSX;
        state_d  = S_FYA;
      end
      S_FYA: begin
        cmd_o.op = OP_FSY;
        state_d  = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

`default_nettype wire

// ===== src/rcn_datapath.sv =====
`default_nettype none

module rcn_datapath import rcn_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dp_cmd_t                   cmd_i,
  output dp_stat_t                       stat_o,
  input  wire logic [SLOT_AW-1:0]        slot_index_i,
  input  wire logic [POS_W-1:0]          centre_x_i,
  input  wire logic [POS_W-1:0]          centre_y_i,
  input  wire logic                      inactive_i,
  input  wire logic signed [DIR_W-1:0]   dir_x_i,
  input  wire logic signed [DIR_W-1:0]   dir_y_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IW-1:0]         cfg_idx_i,
  input  wire logic [CFG_DW-1:0]         cfg_data_i,
  output logic                           hit_o,
  output logic signed [OUT_W-1:0]        contact_x_o,
  output logic signed [OUT_W-1:0]        contact_y_o,
  output logic [POS_W-1:0]               target_x_o,
  output logic [POS_W-1:0]               target_y_o
);

  logic [POS_W-1:0] mem_x [SLOTS];
  logic [POS_W-1:0] mem_y [SLOTS];
  logic [POS_W-1:0] rx_q, ry_q;
  logic [SLOTS-1:0] inact_q;

  logic [CD_W-1:0]    cd_q;
  logic [REACH_W-1:0] reach_q;

  logic signed [DIR_W-1:0] dx_q, dy_q;
  logic [POS_W-1:0]        ox_q, oy_q, cx_q, cy_q, bx_q, by_q;
  logic signed [POS_W:0]   sx_q, sy_q;
  logic signed [MW-1:0]    p_q;
  logic signed [31:0]      b_q, best_t_q, t_d;
  logic [29:0]             d2_q, best_d2_q;
  logic                    have_q;
  logic [OUT_W-1:0]        res_x_q, res_y_q;

  logic signed [31:0] ma, mb, mult;
  logic signed [63:0] prod;
  logic [9:0]         rq;
  logic [19:0]        rsq;
  logic signed [31:0] c;
  logic [MW-1:0]      csh;
  logic               sq_done;
  logic [SQ_STEPS-1:0] sq_root;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WR && {1'b0, slot_index_i} < (SLOT_AW + 1)'(SLOTS)) begin
      mem_x[slot_index_i] <= centre_x_i;
      mem_y[slot_index_i] <= centre_y_i;
    end
    rx_q <= mem_x[cmd_i.addr];
    ry_q <= mem_y[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inact_q <= '1;
      cd_q    <= CD_RESET;
      reach_q <= REACH_RESET;
      have_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_WR) begin
        inact_q[slot_index_i] <= inactive_i;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CONTACT: cd_q    <= cfg_data_i[CD_W-1:0];
          CFG_REACH:   reach_q <= cfg_data_i[REACH_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_QRY) begin
        have_q <= 1'b0;
      end else if (cmd_i.op == OP_UPD) begin
        have_q <= 1'b1;
      end
    end
  end

  assign mult = have_q ? best_t_q : $signed({22'd0, reach_q});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_M1:  begin ma = 32'(sx_q); mb = 32'(dx_q); end
      OP_M2:  begin ma = 32'(sy_q); mb = 32'(dy_q); end
      OP_M3:  begin ma = 32'(sx_q); mb = 32'(sx_q); end
      OP_M4:  begin ma = 32'(sy_q); mb = 32'(sy_q); end
      OP_BB:  begin ma = b_q;       mb = b_q;       end
      OP_FMX: begin ma = 32'(dx_q); mb = mult;      end
      OP_FSX: begin ma = 32'(dy_q); mb = mult;      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  assign rq  = {cd_q, 4'b0};
  assign rsq = rq * rq;
  assign c   = $signed({2'b0, d2_q}) - $signed({12'd0, rsq});
  assign csh = {2'b0, c, 28'd0};
  assign t_d = -b_q - $signed({1'b0, sq_root});

  always_ff @(posedge clk_i) begin
    p_q <= prod[MW-1:0];
    case (cmd_i.op)
      OP_QRY: begin
        dx_q <= dir_x_i;
        dy_q <= dir_y_i;
      end
      OP_ORG: begin
        ox_q <= rx_q;
        oy_q <= ry_q;
      end
      OP_DIFF: begin
        sx_q <= $signed({1'b0, ox_q}) - $signed({1'b0, rx_q});
        sy_q <= $signed({1'b0, oy_q}) - $signed({1'b0, ry_q});
        cx_q <= rx_q;
        cy_q <= ry_q;
      end
      OP_M2: b_q  <= p_q[31:0];
      OP_M3: b_q  <= b_q + p_q[31:0];
      OP_M4: d2_q <= p_q[29:0];
      OP_M5: d2_q <= d2_q + p_q[29:0];
      OP_UPD: begin
        best_t_q  <= t_d;
        best_d2_q <= d2_q;
        bx_q      <= cx_q;
        by_q      <= cy_q;
      end
      OP_FSX: res_x_q <= rnd_sat(ox_q, p_q, have_q);
      OP_FSY: res_y_q <= rnd_sat(oy_q, p_q, have_q);
      default: ;
    endcase
  end

  rcn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQST),
    .v_i     ($unsigned(p_q) - csh),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign stat_o.inact   = inact_q[cmd_i.addr];
  assign stat_o.eval_ok = !c[31] && (b_q[31] || b_q == '0) && (!have_q || d2_q < best_d2_q);
  assign stat_o.h_ok    = $unsigned(p_q) >= csh;
  assign stat_o.sq_done = sq_done;

  assign hit_o       = have_q;
  assign contact_x_o = res_x_q;
  assign contact_y_o = res_y_q;
  assign target_x_o  = have_q ? bx_q : '0;
  assign target_y_o  = have_q ? by_q : '0;

endmodule

`default_nettype wire
